### hw/rtl/sst_pkg.sv
package sst_pkg;

   localparam int SLOT_COUNT = 4;
   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // request kinds
   localparam logic [1:0] REQ_ALLOC  = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_REJECTED  = 2'd2;

   typedef enum logic [1:0] {
      OP_ALLOC,
      OP_LOOKUP,
      OP_CLEAR,
      OP_FIXED
   } op_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] session_id;
      logic [31:0] now_ms;
   } req_item_type;

   typedef struct packed {
      logic [1:0] status;
      logic [1:0] slot_index;
      logic       evicted;
   } rsp_item_type;

   typedef struct packed {
      op_type      op;
      logic [1:0]  status;
      logic [31:0] session_id;
      logic [31:0] now_ms;
   } cmd_item_type;

endpackage

### hw/rtl/sst_front.sv
module sst_front
   import sst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   input  logic         cmd_pop,
   output logic         cmd_valid,
   output cmd_item_type cmd_data
);

   cmd_item_type              queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]         count_ff, count_in;
   cmd_item_type              cmd_in;
   logic                      push;
   logic                      pop;

   // items that need no table access are settled here
   always_comb begin
      cmd_in            = '0;
      cmd_in.session_id = req_data.session_id;
      cmd_in.now_ms     = req_data.now_ms;
      cmd_in.op         = OP_FIXED;
      cmd_in.status     = STAT_NOT_FOUND;
      case (req_data.req_type)
         REQ_ALLOC: begin
            if (req_data.session_id == 32'd0) begin
               cmd_in.status = STAT_REJECTED;
            end else begin
               cmd_in.op = OP_ALLOC;
            end
         end
         REQ_LOOKUP: begin
            if (req_data.session_id != 32'd0) begin
               cmd_in.op = OP_LOOKUP;
            end
         end
         REQ_CLEAR: begin
            if (req_data.session_id != 32'd0) begin
               cmd_in.op = OP_CLEAR;
            end
         end
         default: begin
            cmd_in.op = OP_FIXED;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd_data  = queue_ff[rd_ptr_ff];
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

### hw/rtl/sst_back.sv
module sst_back
   import sst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_item_type cmd_data,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } state_type;

   logic [31:0]           ident_mem [SLOT_COUNT];
   logic [31:0]           used_mem  [SLOT_COUNT];

   state_type             state_ff, state_in;
   cmd_item_type          cmd_ff, cmd_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [31:0]           rd_ident_ff;
   logic [31:0]           rd_used_ff;
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      pick_ff, pick_in;
   logic [IDX_W-1:0]      oldest_ff, oldest_in;
   logic [31:0]           oldest_age_ff, oldest_age_in;
   logic [SLOT_COUNT-1:0] live_ff, live_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;

   logic                  mem_we;
   logic [IDX_W-1:0]      mem_addr;
   logic                  live_slot;
   logic                  match;
   logic [31:0]           age;
   logic                  out_free;
   logic                  issue;

   // an entry without its live bit reads as empty
   assign live_slot = live_ff[rd_idx_ff];
   assign match     = live_slot && (rd_ident_ff == cmd_ff.session_id);
   assign age       = cmd_ff.now_ms - rd_used_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == ST_SCAN) && (scan_ff < CNT_W'(SLOT_COUNT));
   assign mem_addr  = found_ff ? pick_ff : oldest_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      scan_in       = scan_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      found_in      = found_ff;
      pick_in       = pick_ff;
      oldest_in     = oldest_ff;
      oldest_age_in = oldest_age_ff;
      live_in       = live_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      cmd_pop       = 1'b0;
      mem_we        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               cmd_in        = cmd_data;
               scan_in       = '0;
               found_in      = 1'b0;
               pick_in       = '0;
               oldest_in     = '0;
               oldest_age_in = '0;
               state_in      = (cmd_data.op == OP_FIXED) ? ST_WRITE : ST_SCAN;
            end
         end

         ST_SCAN: begin
            // read one slot a cycle, judge it the cycle after
            if (issue) begin
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff[IDX_W-1:0];
               scan_in   = scan_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               case (cmd_ff.op)
                  OP_ALLOC: begin
                     if (!found_ff) begin
                        if (!live_slot) begin
                           found_in = 1'b1;
                           pick_in  = rd_idx_ff;
                        end else if (age >= oldest_age_ff) begin
                           // later slot wins a tie
                           oldest_age_in = age;
                           oldest_in     = rd_idx_ff;
                        end
                     end
                  end
                  OP_LOOKUP: begin
                     if (!found_ff && match) begin
                        found_in = 1'b1;
                        pick_in  = rd_idx_ff;
                     end
                  end
                  OP_CLEAR: begin
                     if (match) begin
                        found_in           = 1'b1;
                        live_in[rd_idx_ff] = 1'b0;
                     end
                  end
                  default: begin
                     found_in = found_ff;
                  end
               endcase
               if (rd_idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
                  state_in = ST_WRITE;
               end
            end
         end

         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               rsp_in       = '0;
               case (cmd_ff.op)
                  OP_ALLOC: begin
                     mem_we            = 1'b1;
                     live_in[mem_addr] = 1'b1;
                     rsp_in.status     = STAT_OK;
                     rsp_in.slot_index = 2'(mem_addr);
                     rsp_in.evicted    = !found_ff;
                  end
                  OP_LOOKUP: begin
                     rsp_in.status     = found_ff ? STAT_OK : STAT_NOT_FOUND;
                     rsp_in.slot_index = found_ff ? 2'(pick_ff) : 2'd0;
                  end
                  OP_CLEAR: begin
                     rsp_in.status = found_ff ? STAT_OK : STAT_NOT_FOUND;
                  end
                  default: begin
                     rsp_in.status = cmd_ff.status;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      scan_ff       <= scan_in;
      rd_idx_ff     <= rd_idx_in;
      found_ff      <= found_in;
      pick_ff       <= pick_in;
      oldest_ff     <= oldest_in;
      oldest_age_ff <= oldest_age_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_ident_ff <= ident_mem[scan_ff[IDX_W-1:0]];
         rd_used_ff  <= used_mem[scan_ff[IDX_W-1:0]];
      end
      if (mem_we) begin
         ident_mem[mem_addr] <= cmd_ff.session_id;
         used_mem[mem_addr]  <= cmd_ff.now_ms;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hw/rtl/session_slot_table_core.sv
// flow: the front queues accepted items; the back pops one, reads the slots in order,
// one slot a cycle, judges each read the cycle after, then registers the result
// in its write state; items settled in the front skip the scan. The back holds one
// item; the two-item queue fills while the scan runs and while a result waits
// reset: synchronous, active high; empties every slot and drops queued items
module session_slot_table_core
   import sst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   logic         cmd_valid;
   logic         cmd_pop;
   cmd_item_type cmd_data;

   sst_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_pop   (cmd_pop),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data)
   );

   sst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
